FILE: rtl/core/fams_pkg.sv
// ----------------------------------------------------------------------------
// fams_pkg
// Widths, codes and small helpers shared by the face mode sequencer.
// ----------------------------------------------------------------------------
package fams_pkg;

  localparam int TIME_BITS  = 48;
  localparam int NOW_W      = 47;
  localparam int KIND_W     = 4;
  localparam int IMG_W      = 8;
  localparam int MODE_W     = 4;
  localparam int BSTG_W     = 27;
  localparam int BTOT_W     = 28;
  localparam int FP_W       = 24;
  localparam int OVL_W      = 27;
  localparam int DISC_W     = 30;
  localparam int CFG_DATA_W = 30;
  localparam int CFG_ADDR_W = 3;
  localparam int CNT_W      = $clog2(TIME_BITS + 1);

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_BOOT_STAGE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BOOT_TOTAL = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_OVERLAY    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_DISCOVERY  = 3'd4;

  localparam logic [BSTG_W-1:0] RST_BOOT_STAGE = 27'd5000000;
  localparam logic [BTOT_W-1:0] RST_BOOT_TOTAL = 28'd10000000;
  localparam logic [FP_W-1:0]   RST_FRAME      = 24'd400000;
  localparam logic [OVL_W-1:0]  RST_OVERLAY    = 27'd5000000;
  localparam logic [DISC_W-1:0] RST_DISCOVERY  = 30'd60000000;

  // Item kinds
  localparam logic [KIND_W-1:0] K_TICK        = 4'd0;
  localparam logic [KIND_W-1:0] K_BOOT        = 4'd1;
  localparam logic [KIND_W-1:0] K_REC_START   = 4'd2;
  localparam logic [KIND_W-1:0] K_REC_STOP    = 4'd3;
  localparam logic [KIND_W-1:0] K_THINK       = 4'd4;
  localparam logic [KIND_W-1:0] K_SPEAK       = 4'd5;
  localparam logic [KIND_W-1:0] K_SPEAK_STOP  = 4'd6;
  localparam logic [KIND_W-1:0] K_ERROR       = 4'd7;
  localparam logic [KIND_W-1:0] K_DISCOVER    = 4'd8;
  localparam logic [KIND_W-1:0] K_CONNECTED   = 4'd9;
  localparam logic [KIND_W-1:0] K_PROOF       = 4'd10;
  localparam logic [KIND_W-1:0] K_PROVISIONED = 4'd11;
  localparam logic [KIND_W-1:0] K_BLE_STOP    = 4'd12;
  localparam logic [KIND_W-1:0] K_TOUCH       = 4'd13;
  localparam logic [KIND_W-1:0] K_EXPRESSION  = 4'd14;
  localparam logic [KIND_W-1:0] K_CUSTOM      = 4'd15;

  // Face modes
  localparam logic [MODE_W-1:0] M_BOOT1  = 4'd0;
  localparam logic [MODE_W-1:0] M_BOOT2  = 4'd1;
  localparam logic [MODE_W-1:0] M_IDLE   = 4'd2;
  localparam logic [MODE_W-1:0] M_OVL    = 4'd3;
  localparam logic [MODE_W-1:0] M_REC    = 4'd4;
  localparam logic [MODE_W-1:0] M_THINK  = 4'd5;
  localparam logic [MODE_W-1:0] M_SPEAK  = 4'd6;
  localparam logic [MODE_W-1:0] M_ERR    = 4'd7;
  localparam logic [MODE_W-1:0] M_DISC   = 4'd8;
  localparam logic [MODE_W-1:0] M_WAIT   = 4'd9;
  localparam logic [MODE_W-1:0] M_PAIROK = 4'd10;

  // Images
  localparam logic [IMG_W-1:0] IMG_BOOT1  = 8'd7;
  localparam logic [IMG_W-1:0] IMG_BOOT2  = 8'd4;
  localparam logic [IMG_W-1:0] IMG_IDLE   = 8'd3;
  localparam logic [IMG_W-1:0] IMG_REC    = 8'd4;
  localparam logic [IMG_W-1:0] IMG_THINK  = 8'd10;
  localparam logic [IMG_W-1:0] IMG_SPEAK  = 8'd2;
  localparam logic [IMG_W-1:0] IMG_ERR    = 8'd14;
  localparam logic [IMG_W-1:0] IMG_DISC   = 8'd1;
  localparam logic [IMG_W-1:0] IMG_WAIT   = 8'd5;
  localparam logic [IMG_W-1:0] IMG_PAIROK = 8'd6;
  localparam logic [IMG_W-1:0] IMG_TOUCH  = 8'd6;
  localparam logic [IMG_W-1:0] IMG_EXPR   = 8'd11;

  typedef struct packed {
    logic [BSTG_W-1:0] boot_stage;
    logic [BTOT_W-1:0] boot_total;
    logic [FP_W-1:0]   frame_period;
    logic [OVL_W-1:0]  overlay_hold;
    logic [DISC_W-1:0] discovery_hold;
  } cfg_t;

  typedef struct packed {
    logic            done;
    logic [1:0]      qmod3;
    logic [FP_W-1:0] rem;
  } div_res_t;

  // Quotient residue mod 3, updated as quotient bits arrive MSB first
  function automatic logic [1:0] mod3_step(input logic [1:0] m, input logic b);
    logic [2:0] t;
    t = {m, b};
    return (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
  endfunction

  // Thinking animation frames
  function automatic logic [IMG_W-1:0] think_img(input logic [1:0] m);
    logic [IMG_W-1:0] img;
    case (m)
      2'd0:    img = 8'd10;
      2'd1:    img = 8'd8;
      default: img = 8'd9;
    endcase
    return img;
  endfunction

endpackage

FILE: rtl/core/fams_if.sv
// ----------------------------------------------------------------------------
// fams_in_if / fams_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface fams_in_if import fams_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [NOW_W-1:0]  now_time;
  logic [IMG_W-1:0]  custom_image;

  modport source (output valid, kind, now_time, custom_image, input ready);
  modport sink   (input valid, kind, now_time, custom_image, output ready);
endinterface

interface fams_out_if import fams_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [IMG_W-1:0]     image_id;
  logic [TIME_BITS-1:0] next_deadline;
  logic                 face_changed;
  logic [MODE_W-1:0]    face_mode;

  modport source (output valid, image_id, next_deadline, face_changed, face_mode,
                  input ready);
  modport sink   (input valid, image_id, next_deadline, face_changed, face_mode,
                  output ready);
endinterface

FILE: rtl/core/fams_cfg.sv
// ----------------------------------------------------------------------------
// fams_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module fams_cfg import fams_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_BOOT_STAGE: cfg_nxt.boot_stage     = cfg_wdata[BSTG_W-1:0];
        CFG_BOOT_TOTAL: cfg_nxt.boot_total     = cfg_wdata[BTOT_W-1:0];
        CFG_FRAME:      cfg_nxt.frame_period   = cfg_wdata[FP_W-1:0];
        CFG_OVERLAY:    cfg_nxt.overlay_hold   = cfg_wdata[OVL_W-1:0];
        CFG_DISCOVERY:  cfg_nxt.discovery_hold = cfg_wdata[DISC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.boot_stage     <= RST_BOOT_STAGE;
      cfg_r.boot_total     <= RST_BOOT_TOTAL;
      cfg_r.frame_period   <= RST_FRAME;
      cfg_r.overlay_hold   <= RST_OVERLAY;
      cfg_r.discovery_hold <= RST_DISCOVERY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/fams_div.sv
// ----------------------------------------------------------------------------
// fams_div
// Bit-serial restoring divider: one quotient bit per cycle, keeps only the
// remainder and the quotient residue mod 3.
// ----------------------------------------------------------------------------
module fams_div import fams_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [TIME_BITS-1:0] dividend,
  input  logic [FP_W-1:0]      divisor,
  output div_res_t             res
);

  logic [TIME_BITS-1:0] dvd_r, dvd_nxt;
  logic [FP_W-1:0]      dsr_r, dsr_nxt;
  logic [FP_W-1:0]      rem_r, rem_nxt;
  logic [1:0]           m3_r, m3_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [FP_W:0]        rem_sh;
  logic [FP_W:0]        rem_sub;
  logic                 qbit;

  assign rem_sh  = {rem_r, dvd_r[TIME_BITS-1]};
  assign qbit    = (rem_sh >= {1'b0, dsr_r});
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    m3_nxt   = m3_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      dsr_nxt  = (divisor == '0) ? FP_W'(1) : divisor;
      rem_nxt  = '0;
      m3_nxt   = '0;
      cnt_nxt  = CNT_W'(TIME_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[TIME_BITS-2:0], 1'b0};
      rem_nxt = qbit ? rem_sub[FP_W-1:0] : rem_sh[FP_W-1:0];
      m3_nxt  = mod3_step(m3_r, qbit);
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
    m3_r  <= m3_nxt;
  end

  assign res.done  = done_r;
  assign res.qmod3 = m3_r;
  assign res.rem   = rem_r;

endmodule

FILE: rtl/core/face_animation_mode_sequencer_core.sv
// ----------------------------------------------------------------------------
// face_animation_mode_sequencer_core
// Face mode sequencer: events set mode, image and deadline; a tick runs the
// update and returns one result item.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   kind, now_time, custom_image
//   out_ch   out  valid/ready   image_id, next_deadline, face_changed, face_mode
//   cfg_*    in   cfg_we        cfg_addr, cfg_wdata
//
// Events are applied in the idle step; ready stays high after them.
// A tick runs the difference, evaluate and output steps, with the bit-serial
// divider for the frame number and the frame step before output in thinking mode.
// The output register holds a result until taken; a new item is accepted
// meanwhile, and a following tick holds in its last step until the register frees.
// Synchronous active-low reset puts the face in boot stage one.
// ----------------------------------------------------------------------------
module face_animation_mode_sequencer_core import fams_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  fams_in_if.sink               in_ch,
  fams_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIFF = 6'b000010,
    S_EVAL = 6'b000100,
    S_DIV  = 6'b001000,
    S_THK  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  localparam int TB = TIME_BITS;

  state_t               state_r, state_nxt;
  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [IMG_W-1:0]     image_r, image_nxt;
  logic [TB-1:0]        boot_start_r, boot_start_nxt;
  logic [TB-1:0]        deadline_r, deadline_nxt;
  logic [TB-1:0]        think_start_r, think_start_nxt;
  logic                 pending_r, pending_nxt;
  logic                 chg_r, chg_nxt;
  logic [TB-1:0]        now_r, now_nxt;
  logic [TB-1:0]        bel_r, bel_nxt;
  logic [TB-1:0]        tel_r, tel_nxt;
  logic [TB-1:0]        acc_r, acc_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [IMG_W-1:0]     out_img_r, out_img_nxt;
  logic [TB-1:0]        out_dl_r, out_dl_nxt;
  logic                 out_chg_r, out_chg_nxt;
  logic [MODE_W-1:0]    out_mode_r, out_mode_nxt;

  cfg_t                 cfg;
  div_res_t             div_res;
  logic                 div_start;
  logic [TB-1:0]        div_dvd;

  logic                 in_acc;
  logic [TB-1:0]        now_ext;
  logic [TB-1:0]        ev_add;
  logic [TB-1:0]        ev_dl;
  logic                 is_idle;
  logic                 ge_total;
  logic                 ge_stage;
  logic [TB-1:0]        fp_eff;
  logic [IMG_W-1:0]     frame_img;

  fams_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Clamp negative elapsed time to zero
  assign div_dvd = tel_r[TB-1] ? '0 : tel_r;

  fams_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (cfg.frame_period),
    .res      (div_res)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign now_ext     = TB'(in_ch.now_time);
  assign is_idle     = (mode_r == M_IDLE) || (mode_r == M_OVL);

  always_comb begin
    case (in_ch.kind)
      K_BOOT:   ev_add = TB'(cfg.boot_stage);
      K_THINK:  ev_add = TB'(cfg.frame_period);
      K_DISCOVER: ev_add = TB'(cfg.discovery_hold);
      default:  ev_add = TB'(cfg.overlay_hold);
    endcase
  end
  assign ev_dl = now_ext + ev_add;

  assign ge_total  = !bel_r[TB-1] && (bel_r >= TB'(cfg.boot_total));
  assign ge_stage  = !bel_r[TB-1] && (bel_r >= TB'(cfg.boot_stage));
  assign fp_eff    = (cfg.frame_period == '0) ? TB'(1) : TB'(cfg.frame_period);
  assign frame_img = think_img(div_res.qmod3);

  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    image_nxt       = image_r;
    boot_start_nxt  = boot_start_r;
    deadline_nxt    = deadline_r;
    think_start_nxt = think_start_r;
    pending_nxt     = pending_r;
    chg_nxt         = chg_r;
    now_nxt         = now_r;
    bel_nxt         = bel_r;
    tel_nxt         = tel_r;
    acc_nxt         = acc_r;
    div_start       = 1'b0;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_img_nxt     = out_img_r;
    out_dl_nxt      = out_dl_r;
    out_chg_nxt     = out_chg_r;
    out_mode_nxt    = out_mode_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_ch.kind)
            K_TICK: begin
              now_nxt     = now_ext;
              chg_nxt     = pending_r;
              pending_nxt = 1'b0;
              state_nxt   = S_DIFF;
            end
            K_BOOT: begin
              mode_nxt        = M_BOOT1;
              image_nxt       = IMG_BOOT1;
              boot_start_nxt  = now_ext;
              deadline_nxt    = ev_dl;
              think_start_nxt = '0;
              pending_nxt     = 1'b1;
            end
            K_REC_START: begin
              mode_nxt = M_REC; image_nxt = IMG_REC;
              deadline_nxt = '0; pending_nxt = 1'b1;
            end
            K_THINK: begin
              mode_nxt = M_THINK; image_nxt = IMG_THINK;
              deadline_nxt = ev_dl; think_start_nxt = now_ext; pending_nxt = 1'b1;
            end
            K_SPEAK: begin
              mode_nxt = M_SPEAK; image_nxt = IMG_SPEAK;
              deadline_nxt = '0; pending_nxt = 1'b1;
            end
            K_SPEAK_STOP: begin
              mode_nxt = M_IDLE; image_nxt = IMG_IDLE;
              deadline_nxt = '0; pending_nxt = 1'b1;
            end
            K_ERROR: begin
              mode_nxt = M_ERR; image_nxt = IMG_ERR;
              deadline_nxt = ev_dl; pending_nxt = 1'b1;
            end
            K_DISCOVER: begin
              mode_nxt = M_DISC; image_nxt = IMG_DISC;
              deadline_nxt = ev_dl; pending_nxt = 1'b1;
            end
            K_CONNECTED: begin
              mode_nxt = M_WAIT; image_nxt = IMG_WAIT;
              deadline_nxt = '0; pending_nxt = 1'b1;
            end
            K_PROOF, K_PROVISIONED: begin
              mode_nxt = M_PAIROK; image_nxt = IMG_PAIROK;
              deadline_nxt = ev_dl; pending_nxt = 1'b1;
            end
            K_BLE_STOP: begin
              if (mode_r == M_DISC || mode_r == M_WAIT) begin
                mode_nxt = M_IDLE; image_nxt = IMG_IDLE;
                deadline_nxt = '0; pending_nxt = 1'b1;
              end
            end
            K_TOUCH, K_EXPRESSION, K_CUSTOM: begin
              if (is_idle) begin
                mode_nxt     = M_OVL;
                deadline_nxt = ev_dl;
                pending_nxt  = 1'b1;
                case (in_ch.kind)
                  K_TOUCH:      image_nxt = IMG_TOUCH;
                  K_EXPRESSION: image_nxt = IMG_EXPR;
                  default:      image_nxt = in_ch.custom_image;
                endcase
              end
            end
            default: ;  // recording stop has no effect
          endcase
        end
      end
      S_DIFF: begin
        bel_nxt   = now_r - boot_start_r;
        tel_nxt   = now_r - think_start_r;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_OUT;
        case (mode_r)
          M_BOOT1, M_BOOT2: begin
            if (ge_total) begin
              mode_nxt = M_IDLE; image_nxt = IMG_IDLE;
              deadline_nxt = '0; chg_nxt = 1'b1;
            end else if (mode_r == M_BOOT1 && ge_stage) begin
              mode_nxt     = M_BOOT2;
              image_nxt    = IMG_BOOT2;
              deadline_nxt = boot_start_r + TB'(cfg.boot_total);
              chg_nxt      = 1'b1;
            end
          end
          M_THINK: begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
          M_PAIROK, M_ERR, M_OVL, M_DISC: begin
            if (now_r >= deadline_r) begin
              mode_nxt = M_IDLE; image_nxt = IMG_IDLE;
              deadline_nxt = '0; chg_nxt = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_DIV: begin
        if (div_res.done) begin
          // start + elapsed is now, or the start itself when clamped
          acc_nxt   = (tel_r[TB-1] ? think_start_r : now_r) - TB'(div_res.rem);
          state_nxt = S_THK;
        end
      end
      S_THK: begin
        deadline_nxt = acc_r + fp_eff;
        if (frame_img != image_r) begin
          image_nxt = frame_img;
          chg_nxt   = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_img_nxt   = image_r;
          out_dl_nxt    = deadline_r;
          out_chg_nxt   = chg_r;
          out_mode_nxt  = mode_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      mode_r        <= M_BOOT1;
      image_r       <= IMG_BOOT1;
      boot_start_r  <= '0;
      deadline_r    <= TB'(RST_BOOT_STAGE);
      think_start_r <= '0;
      pending_r     <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      mode_r        <= mode_nxt;
      image_r       <= image_nxt;
      boot_start_r  <= boot_start_nxt;
      deadline_r    <= deadline_nxt;
      think_start_r <= think_start_nxt;
      pending_r     <= pending_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chg_r      <= chg_nxt;
    now_r      <= now_nxt;
    bel_r      <= bel_nxt;
    tel_r      <= tel_nxt;
    acc_r      <= acc_nxt;
    out_img_r  <= out_img_nxt;
    out_dl_r   <= out_dl_nxt;
    out_chg_r  <= out_chg_nxt;
    out_mode_r <= out_mode_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.image_id      = out_img_r;
  assign out_ch.next_deadline = out_dl_r;
  assign out_ch.face_changed  = out_chg_r;
  assign out_ch.face_mode     = out_mode_r;

`ifndef NO_ASSERTIONS
  a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.kind == K_TICK) |=> (state_r == S_DIFF))
    else $error("tick item did not start the update");

  a_out_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result appeared outside the output step");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide step");

  a_div_only_thinking: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (mode_r == M_THINK))
    else $error("divider started outside thinking mode");
`endif

endmodule

FILE: test/face_animation_mode_sequencer_checker.sv
// ----------------------------------------------------------------------------
// face_animation_mode_sequencer_checker
// Watches the item channels and the register port of the face mode
// sequencer, predicts the result of every tick and compares it with what
// the block returns, oldest first.
// ----------------------------------------------------------------------------
module face_animation_mode_sequencer_checker import fams_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  fams_in_if                    in_mon,
  fams_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           fail_count,
  output int unsigned           open_count
);

  localparam int unsigned      REPORT_MAX  = 10;
  localparam logic [IMG_W-1:0] IMG_THINK_B = 8'd8;
  localparam logic [IMG_W-1:0] IMG_THINK_C = 8'd9;

  typedef struct packed {
    logic [IMG_W-1:0]     image_id;
    logic [TIME_BITS-1:0] next_deadline;
    logic                 face_changed;
    logic [MODE_W-1:0]    face_mode;
  } face_result_t;

  cfg_t                 regs;
  logic [MODE_W-1:0]    mode_q;
  logic [IMG_W-1:0]     image_q;
  logic [TIME_BITS-1:0] boot_t0;
  logic [TIME_BITS-1:0] deadline_q;
  logic [TIME_BITS-1:0] think_t0;
  logic                 change_pending;
  face_result_t         face_q[$];
  int unsigned          errors = 0;

  function automatic void enter_mode(input logic [MODE_W-1:0] m, input logic [IMG_W-1:0] img,
                                     input logic [TIME_BITS-1:0] dl);
    mode_q         = m;
    image_q        = img;
    deadline_q     = dl;
    change_pending = 1'b1;
  endfunction

  function automatic void restart_boot(input logic [TIME_BITS-1:0] now);
    mode_q         = M_BOOT1;
    image_q        = IMG_BOOT1;
    boot_t0        = now;
    deadline_q     = now + TIME_BITS'(regs.boot_stage);
    think_t0       = '0;
    change_pending = 1'b1;
  endfunction

  // signed elapsed time, negative never reaches the threshold
  function automatic logic reached(input logic [TIME_BITS-1:0] now, since, thr);
    logic [TIME_BITS-1:0] d;
    d = now - since;
    return !d[TIME_BITS-1] && (d >= thr);
  endfunction

  function automatic logic idle_face();
    return (mode_q == M_IDLE) || (mode_q == M_OVL);
  endfunction

  function automatic face_result_t run_tick(input logic [TIME_BITS-1:0] now);
    face_result_t         r;
    logic                 chg;
    logic [TIME_BITS-1:0] fp;
    logic [TIME_BITS-1:0] e;
    logic [TIME_BITS-1:0] q;
    logic [1:0]           frame;
    logic [IMG_W-1:0]     img;
    chg = change_pending;
    change_pending = 1'b0;
    case (mode_q)
      M_BOOT1, M_BOOT2: begin
        if (reached(now, boot_t0, TIME_BITS'(regs.boot_total))) begin
          enter_mode(M_IDLE, IMG_IDLE, '0);
          chg = 1'b1;
        end else if (mode_q == M_BOOT1 &&
                     reached(now, boot_t0, TIME_BITS'(regs.boot_stage))) begin
          enter_mode(M_BOOT2, IMG_BOOT2, boot_t0 + TIME_BITS'(regs.boot_total));
          chg = 1'b1;
        end
      end
      M_THINK: begin
        fp = (regs.frame_period == '0) ? TIME_BITS'(1) : TIME_BITS'(regs.frame_period);
        e = now - think_t0;
        if (e[TIME_BITS-1]) e = '0;
        q = e / fp;
        frame = 2'(q % 3);
        case (frame)
          2'd0:    img = IMG_THINK;
          2'd1:    img = IMG_THINK_B;
          default: img = IMG_THINK_C;
        endcase
        if (img != image_q) begin
          image_q = img;
          chg = 1'b1;
        end
        deadline_q = think_t0 + (q + 1) * fp;
      end
      M_PAIROK, M_ERR, M_OVL, M_DISC: begin
        if (now >= deadline_q) begin
          enter_mode(M_IDLE, IMG_IDLE, '0);
          chg = 1'b1;
        end
      end
      default: ;
    endcase
    change_pending = 1'b0;
    r.image_id      = image_q;
    r.next_deadline = deadline_q;
    r.face_changed  = chg;
    r.face_mode     = mode_q;
    return r;
  endfunction

  function automatic void apply_event(input logic [KIND_W-1:0] kind,
                                      input logic [TIME_BITS-1:0] now,
                                      input logic [IMG_W-1:0] cimg);
    case (kind)
      K_BOOT:       restart_boot(now);
      K_REC_START:  enter_mode(M_REC, IMG_REC, '0);
      K_REC_STOP:   ;
      K_THINK: begin
        enter_mode(M_THINK, IMG_THINK, now + TIME_BITS'(regs.frame_period));
        think_t0 = now;
      end
      K_SPEAK:      enter_mode(M_SPEAK, IMG_SPEAK, '0);
      K_SPEAK_STOP: enter_mode(M_IDLE, IMG_IDLE, '0);
      K_ERROR:      enter_mode(M_ERR, IMG_ERR, now + TIME_BITS'(regs.overlay_hold));
      K_DISCOVER:   enter_mode(M_DISC, IMG_DISC, now + TIME_BITS'(regs.discovery_hold));
      K_CONNECTED:  enter_mode(M_WAIT, IMG_WAIT, '0);
      K_PROOF, K_PROVISIONED:
        enter_mode(M_PAIROK, IMG_PAIROK, now + TIME_BITS'(regs.overlay_hold));
      K_BLE_STOP: begin
        if (mode_q == M_DISC || mode_q == M_WAIT) enter_mode(M_IDLE, IMG_IDLE, '0);
      end
      K_TOUCH: begin
        if (idle_face()) enter_mode(M_OVL, IMG_TOUCH, now + TIME_BITS'(regs.overlay_hold));
      end
      K_EXPRESSION: begin
        if (idle_face()) enter_mode(M_OVL, IMG_EXPR, now + TIME_BITS'(regs.overlay_hold));
      end
      default: begin
        if (idle_face()) enter_mode(M_OVL, cimg, now + TIME_BITS'(regs.overlay_hold));
      end
    endcase
  endfunction

  always @(posedge clk) begin : watch
    face_result_t         got;
    face_result_t         want;
    logic [TIME_BITS-1:0] now48;
    if (!rst_n) begin
      regs.boot_stage     = RST_BOOT_STAGE;
      regs.boot_total     = RST_BOOT_TOTAL;
      regs.frame_period   = RST_FRAME;
      regs.overlay_hold   = RST_OVERLAY;
      regs.discovery_hold = RST_DISCOVERY;
      restart_boot('0);
      face_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_BOOT_STAGE: regs.boot_stage     = cfg_wdata[BSTG_W-1:0];
          CFG_BOOT_TOTAL: regs.boot_total     = cfg_wdata[BTOT_W-1:0];
          CFG_FRAME:      regs.frame_period   = cfg_wdata[FP_W-1:0];
          CFG_OVERLAY:    regs.overlay_hold   = cfg_wdata[OVL_W-1:0];
          CFG_DISCOVERY:  regs.discovery_hold = cfg_wdata[DISC_W-1:0];
          default: ;
        endcase
      end
      // results first, so a tick taken at the same edge is not matched
      if (out_mon.valid && out_mon.ready) begin
        got.image_id      = out_mon.image_id;
        got.next_deadline = out_mon.next_deadline;
        got.face_changed  = out_mon.face_changed;
        got.face_mode     = out_mon.face_mode;
        if (face_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("unexpected face result: img=%0d dl=%0d chg=%0b mode=%0d",
                     got.image_id, got.next_deadline, got.face_changed, got.face_mode);
        end else begin
          want = face_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("face result mismatch: want img=%0d dl=%0d chg=%0b mode=%0d, got img=%0d dl=%0d chg=%0b mode=%0d",
                       want.image_id, want.next_deadline, want.face_changed, want.face_mode,
                       got.image_id, got.next_deadline, got.face_changed, got.face_mode);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        now48 = {1'b0, in_mon.now_time};
        if (in_mon.kind == K_TICK) face_q.push_back(run_tick(now48));
        else apply_event(in_mon.kind, now48, in_mon.custom_image);
      end
    end
    fail_count <= errors;
    open_count <= face_q.size();
  end

endmodule

FILE: test/face_animation_mode_sequencer_core_test.sv
// ----------------------------------------------------------------------------
// face_animation_mode_sequencer_core_test
// Drives events and ticks into the face mode sequencer under several register
// settings and idle patterns; the checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
module face_animation_mode_sequencer_core_test;
  import fams_pkg::*;

  localparam int unsigned           SETTLE_CYCLES  = 100;
  localparam int unsigned           WATCHDOG_LIMIT = 4000;
  localparam int unsigned           ITEMS_PER_SET  = 180;
  localparam int unsigned           SET_COUNT      = 6;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED     = 3'd7;
  localparam logic [NOW_W-1:0]      NOW_MAX        = '1;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           fail_count;
  int unsigned           open_count;
  int unsigned           send_gap_pct = 33;
  int unsigned           recv_gap_pct = 80;
  int unsigned           items_sent = 0;
  int unsigned           idle_cycles = 0;
  logic [NOW_W-1:0]      clock_us = '0;
  cfg_t                  cur_cfg;

  fams_in_if  in_ch ();
  fams_out_if out_ch ();

  face_animation_mode_sequencer_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  face_animation_mode_sequencer_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // cycles without any accepted item or result
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog expired");
    $display("CHECK FAILED");
    $finish;
  end

  task automatic push_item(input logic [KIND_W-1:0] kind, input logic [NOW_W-1:0] now_us,
                           input logic [IMG_W-1:0] img);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.now_time     <= now_us;
    in_ch.custom_image <= img;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    items_sent++;
  endtask

  task automatic step_time(input int unsigned scale);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) clock_us = NOW_W'({$urandom, $urandom});
    else if (r < 5) clock_us = clock_us - NOW_W'($urandom_range(scale));
    else if (r < 7) clock_us = NOW_MAX - NOW_W'($urandom_range(scale));
    else clock_us = clock_us + NOW_W'($urandom_range(scale));
  endtask

  task automatic send_at(input logic [KIND_W-1:0] kind, input int unsigned scale);
    step_time(scale);
    push_item(kind, clock_us, IMG_W'($urandom));
  endtask

  task automatic tick_run(input int unsigned n, input int unsigned scale);
    repeat (n) send_at(K_TICK, scale);
  endtask

  // stop sending until every tick has its result, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (open_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t s, input bit wide, input bit poke_unused);
    logic [CFG_DATA_W-1:0] fill;
    fill = '1;
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_BOOT_STAGE;
    cfg_wdata <= wide ? fill : CFG_DATA_W'(s.boot_stage);
    @(posedge clk);
    cfg_addr  <= CFG_BOOT_TOTAL;
    cfg_wdata <= wide ? fill : CFG_DATA_W'(s.boot_total);
    @(posedge clk);
    cfg_addr  <= CFG_FRAME;
    cfg_wdata <= wide ? fill : CFG_DATA_W'(s.frame_period);
    @(posedge clk);
    cfg_addr  <= CFG_OVERLAY;
    cfg_wdata <= wide ? fill : CFG_DATA_W'(s.overlay_hold);
    @(posedge clk);
    cfg_addr  <= CFG_DISCOVERY;
    cfg_wdata <= wide ? fill : CFG_DATA_W'(s.discovery_hold);
    @(posedge clk);
    if (poke_unused) begin
      cfg_addr  <= CFG_UNUSED;
      cfg_wdata <= CFG_DATA_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_cfg = s;
  endtask

  function automatic cfg_t make_setting(input int unsigned which);
    cfg_t s;
    case (which)
      0: begin
        s.boot_stage     = BSTG_W'($urandom_range(100000000, 1));
        s.boot_total     = BTOT_W'($urandom_range(200000000, 1));
        s.frame_period   = FP_W'($urandom_range(10000000, 1));
        s.overlay_hold   = OVL_W'($urandom_range(100000000, 1));
        s.discovery_hold = DISC_W'($urandom_range(600000000, 1));
      end
      1: begin
        // zero frame period counts as one
        s.boot_stage     = BSTG_W'(1);
        s.boot_total     = BTOT_W'(1);
        s.frame_period   = '0;
        s.overlay_hold   = OVL_W'(1);
        s.discovery_hold = DISC_W'(1);
      end
      2: begin
        s.boot_stage     = BSTG_W'(100000000);
        s.boot_total     = BTOT_W'(200000000);
        s.frame_period   = FP_W'(10000000);
        s.overlay_hold   = OVL_W'(100000000);
        s.discovery_hold = DISC_W'(600000000);
      end
      3: s = '1;
      4: begin
        s.boot_stage     = BSTG_W'($urandom_range(2000, 1));
        s.boot_total     = BTOT_W'($urandom_range(4000, 1));
        s.frame_period   = FP_W'($urandom_range(300, 1));
        s.overlay_hold   = OVL_W'($urandom_range(2000, 1));
        s.discovery_hold = DISC_W'($urandom_range(5000, 1));
      end
      default: begin
        s.boot_stage     = RST_BOOT_STAGE;
        s.boot_total     = RST_BOOT_TOTAL;
        s.frame_period   = RST_FRAME;
        s.overlay_hold   = RST_OVERLAY;
        s.discovery_hold = RST_DISCOVERY;
      end
    endcase
    return s;
  endfunction

  function automatic int unsigned span(input logic [31:0] v, input int unsigned div);
    return v / div + 1;
  endfunction

  function automatic logic [KIND_W-1:0] overlay_kind();
    case ($urandom_range(2))
      0:       return K_TOUCH;
      1:       return K_EXPRESSION;
      default: return K_CUSTOM;
    endcase
  endfunction

  task automatic run_scenario();
    int unsigned ovl_span;
    ovl_span = span(32'(cur_cfg.overlay_hold), 2);
    case ($urandom_range(5))
      0: begin
        send_at(K_BOOT, 1000);
        tick_run($urandom_range(10, 4), span(32'(cur_cfg.boot_total), 3));
      end
      1: begin
        send_at(K_THINK, 1000);
        tick_run($urandom_range(12, 3), 2 * 32'(cur_cfg.frame_period) + 1);
        if ($urandom_range(1)) send_at(K_SPEAK_STOP, 10);
      end
      2: begin
        send_at(K_SPEAK_STOP, 100);
        send_at(overlay_kind(), 100);
        tick_run($urandom_range(6, 2), ovl_span);
        if ($urandom_range(1)) send_at(overlay_kind(), 100);
        tick_run($urandom_range(4, 1), ovl_span);
      end
      3: begin
        send_at(K_DISCOVER, 100);
        tick_run($urandom_range(4, 1), span(32'(cur_cfg.discovery_hold), 3));
        case ($urandom_range(3))
          0: send_at(K_BLE_STOP, 100);
          1: begin
            send_at(K_CONNECTED, 100);
            send_at(K_BLE_STOP, 100);
          end
          2: begin
            send_at(K_CONNECTED, 100);
            send_at(K_PROOF, 100);
          end
          default: send_at(K_PROVISIONED, 100);
        endcase
        tick_run($urandom_range(5, 1), ovl_span);
      end
      4: begin
        case ($urandom_range(3))
          0: send_at(K_REC_START, 100);
          1: begin
            send_at(K_REC_START, 100);
            send_at(K_REC_STOP, 100);
          end
          2: send_at(K_SPEAK, 100);
          default: send_at(K_ERROR, 100);
        endcase
        send_at(overlay_kind(), 100);
        tick_run($urandom_range(4, 1), ovl_span);
      end
      default: begin
        repeat ($urandom_range(8, 3)) send_at(KIND_W'($urandom), ovl_span);
      end
    endcase
  endtask

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_addr           <= CFG_BOOT_STAGE;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.kind         <= K_TICK;
    in_ch.now_time     <= '0;
    in_ch.custom_image <= '0;
    cur_cfg = make_setting(SET_COUNT - 1);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed walk through the modes under reset settings
    push_item(K_TICK, 0, 0);               // reset leaves a change flagged
    push_item(K_TICK, 4999999, 0);
    push_item(K_TOUCH, 5000000, 0);        // ignored outside idle
    push_item(K_TICK, 5000000, 0);
    push_item(K_TICK, 10000000, 0);
    push_item(K_CUSTOM, 10000001, 8'hFF);
    push_item(K_EXPRESSION, 10000002, 0);  // overlay acts in overlay mode too
    push_item(K_TICK, 15000002, 0);        // timeout exactly at deadline
    push_item(K_CUSTOM, 15000003, 8'h00);
    push_item(K_REC_STOP, 15000004, 0);
    push_item(K_REC_START, 15000005, 0);
    push_item(K_TICK, 15000006, 0);
    push_item(K_THINK, 20000000, 0);
    push_item(K_TICK, 19999999, 0);        // before start: clamped to frame zero
    push_item(K_TICK, 20400000, 0);
    push_item(K_TICK, 21200000, 0);        // frame three wraps to first image
    push_item(K_BLE_STOP, 21200001, 0);    // ignored while thinking
    push_item(K_DISCOVER, 21300000, 0);
    push_item(K_CONNECTED, 21300001, 0);
    push_item(K_BLE_STOP, 21300002, 0);
    push_item(K_ERROR, 21300003, 0);
    push_item(K_TICK, 26300003, 0);
    push_item(K_SPEAK, 26300004, 0);
    push_item(K_PROOF, 26300005, 0);
    push_item(K_PROVISIONED, 26300006, 0);
    push_item(K_BOOT, NOW_MAX, 0);
    push_item(K_TICK, 0, 0);               // wrapped time reads as negative elapsed
    clock_us = '0;

    for (int unsigned set = 0; set < SET_COUNT; set++) begin
      case (set / 2)
        0: begin
          send_gap_pct = 33;
          recv_gap_pct = 80;
        end
        1: begin
          send_gap_pct = 80;
          recv_gap_pct = 33;
        end
        default: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end
      endcase
      drain();
      apply_settings(make_setting(set), set == 3, set == 3);
      push_item(K_BOOT, clock_us, 0);
      while (items_sent < (set + 1) * ITEMS_PER_SET + 27) begin
        run_scenario();
        if ($urandom_range(49) == 0) drain();
      end
    end
    drain();

    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
